// File: hw/rtl/sfr_pkg.sv
// Shared types and constants of the serial frame receiver.
// Used by sfr_core, sfr_obuf and serial_frame_receiver_unit; no dependencies.
package sfr_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ObufDepth = 2;
  localparam int unsigned ObufCntW  = $clog2(ObufDepth + 1);

  localparam logic [WordW-1:0] MinFrameLen  = 16'd7;
  localparam logic [WordW-1:0] HeaderLen    = 16'd3;
  localparam logic [WordW-1:0] TrailerLen   = 16'd3;
  localparam logic [WordW-1:0] OverheadLen  = 16'd6;
  localparam logic [WordW-1:0] FirstLenIdx  = 16'd1;
  localparam logic [WordW-1:0] SecondLenIdx = 16'd2;
  localparam logic [WordW-1:0] GapMax       = 16'hFFFF;

  localparam logic [ByteW-1:0] StartByteRst    = 8'd2;
  localparam logic [ByteW-1:0] EndByteRst      = 8'd3;
  localparam logic [WordW-1:0] TimeoutTicksRst = 16'd1000;
  localparam logic [WordW-1:0] LengthLimitRst  = 16'd1008;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_END_BYTE      = 2'd1,
    CFG_TIMEOUT_TICKS = 2'd2,
    CFG_LENGTH_LIMIT  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_TOO_SHORT = 3'd2,
    ST_NO_END    = 3'd3,
    ST_BAD_SUM   = 3'd4,
    ST_TIMEOUT   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_END  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] end_byte;
    logic [WordW-1:0] timeout_ticks;
    logic [WordW-1:0] length_limit;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] payload_byte;
    logic [WordW-1:0] payload_offset;
    status_e          status;
    logic [ByteW-1:0] command;
    logic [WordW-1:0] payload_count;
  } result_t;

  typedef struct packed {
    logic                space;
    logic [ObufCntW-1:0] count;
  } obuf_stat_t;

endpackage

// File: hw/rtl/sfr_core.sv
// Frame parser: frame state registers and the per-item next-state logic.
// Depends on sfr_pkg.
module sfr_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  logic                          op_i,
  input  logic [sfr_pkg::ByteW-1:0]     byte_i,
  input  sfr_pkg::cfg_t                 cfg_i,
  output logic                          res_valid_o,
  output sfr_pkg::result_t              res_o
);
  import sfr_pkg::*;

  phase_e           phase_q, phase_d;
  logic [WordW-1:0] idx_q, idx_d;
  logic [WordW-1:0] len_q, len_d;
  logic [WordW-1:0] sum_q, sum_d;
  logic [WordW-1:0] csum_q, csum_d;
  logic [ByteW-1:0] first_q, first_d;
  logic [WordW-1:0] gap_q, gap_d;
  logic             tmr_q, tmr_d;

  logic [WordW-1:0] gap_inc;
  logic [WordW-1:0] len_full;
  logic [WordW-1:0] body_end;
  logic [WordW-1:0] chk;

  assign gap_inc  = (gap_q != GapMax) ? gap_q + 16'd1 : gap_q;
  assign len_full = {len_q[WordW-1:ByteW], byte_i};
  assign body_end = len_q - TrailerLen;
  assign chk      = sum_q + csum_q;

  always_comb begin
    phase_d     = phase_q;
    idx_d       = idx_q;
    len_d       = len_q;
    sum_d       = sum_q;
    csum_d      = csum_q;
    first_d     = first_q;
    gap_d       = gap_q;
    tmr_d       = tmr_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind  = KIND_PAYLOAD;
    res_o.status = ST_OK;
    if (fire_i) begin
      if (op_i == OP_TICK) begin
        if (tmr_q) begin
          gap_d = gap_inc;
          if (gap_inc > cfg_i.timeout_ticks) begin
            phase_d      = PH_IDLE;
            tmr_d        = 1'b0;
            res_valid_o  = 1'b1;
            res_o.kind   = KIND_ERROR;
            res_o.status = ST_TIMEOUT;
          end
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
            if (byte_i == cfg_i.start_byte) begin
              phase_d = PH_LEN;
              idx_d   = FirstLenIdx;
              len_d   = '0;
              sum_d   = '0;
              csum_d  = '0;
              first_d = '0;
              gap_d   = '0;
              tmr_d   = 1'b1;
            end
          end
          PH_LEN: begin
            gap_d = '0;
            if (idx_q == FirstLenIdx) begin
              len_d = {byte_i, {ByteW{1'b0}}};
              idx_d = SecondLenIdx;
            end else begin
              len_d = len_full;
              idx_d = HeaderLen;
              if (len_full >= cfg_i.length_limit) begin
                phase_d      = PH_IDLE;
                tmr_d        = 1'b0;
                res_valid_o  = 1'b1;
                res_o.kind   = KIND_ERROR;
                res_o.status = ST_TOO_LONG;
              end else if (len_full < MinFrameLen) begin
                phase_d      = PH_IDLE;
                tmr_d        = 1'b0;
                res_valid_o  = 1'b1;
                res_o.kind   = KIND_ERROR;
                res_o.status = ST_TOO_SHORT;
              end else begin
                phase_d = PH_BODY;
              end
            end
          end
          PH_BODY: begin
            gap_d = '0;
            idx_d = idx_q + 16'd1;
            if (idx_q < body_end) begin
              if (idx_q == HeaderLen) begin
                first_d = byte_i;
              end
              sum_d                = sum_q + {{(WordW-ByteW){1'b0}}, byte_i};
              res_valid_o          = 1'b1;
              res_o.kind           = KIND_PAYLOAD;
              res_o.payload_byte   = byte_i;
              res_o.payload_offset = idx_q - HeaderLen;
            end else if (idx_q == body_end) begin
              csum_d = {byte_i, {ByteW{1'b0}}};
            end else begin
              csum_d  = {csum_q[WordW-1:ByteW], byte_i};
              phase_d = PH_END;
            end
          end
          PH_END: begin
            gap_d       = '0;
            phase_d     = PH_IDLE;
            tmr_d       = 1'b0;
            res_valid_o = 1'b1;
            if (byte_i != cfg_i.end_byte) begin
              res_o.kind   = KIND_ERROR;
              res_o.status = ST_NO_END;
            end else if (chk != '0) begin
              res_o.kind   = KIND_ERROR;
              res_o.status = ST_BAD_SUM;
            end else begin
              res_o.kind          = KIND_DONE;
              res_o.command       = first_q;
              res_o.payload_count = len_q - OverheadLen;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            tmr_d   = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      idx_q   <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      csum_q  <= '0;
      first_q <= '0;
      gap_q   <= '0;
      tmr_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      csum_q  <= csum_d;
      first_q <= first_d;
      gap_q   <= gap_d;
      tmr_q   <= tmr_d;
    end
  end

endmodule

// File: hw/rtl/sfr_obuf.sv
// Two-entry result buffer that decouples the parser from the output channel.
// Depends on sfr_pkg.
module sfr_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfr_pkg::result_t     push_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfr_pkg::result_t     out_data_o,
  output sfr_pkg::obuf_stat_t  stat_o
);
  import sfr_pkg::*;

  result_t             mem_q [ObufDepth];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [ObufCntW-1:0] cnt_q, cnt_d;
  logic                pop;

  assign out_valid_o  = (cnt_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  assign out_data_o   = mem_q[rd_ptr_q];
  assign stat_o.count = cnt_q;
  assign stat_o.space = (cnt_q != ObufCntW'(ObufDepth)) || out_ready_i;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + ObufCntW'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - ObufCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: hw/rtl/serial_frame_receiver_unit.sv
// Top level of the serial frame receiver: input register, configuration
// registers, parser core and result buffer. Depends on sfr_pkg, sfr_core, sfr_obuf.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i/in_ready_o   operation_i, rx_byte_i
//   out      output     out_valid_o/out_ready_i kind_o .. payload_count_o
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One item per cycle is taken while the result buffer has room; an item's result
// passes through the input register and then the result buffer before it is offered.
// The parser advances one item per cycle as long as the two-entry result
// buffer has room, so a stalled output keeps accepting until both fill.
// Reset returns the parser to idle and loads the default configuration.
module serial_frame_receiver_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           operation_i,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     payload_byte_o,
  output logic [15:0]                    payload_offset_o,
  output logic [2:0]                     status_o,
  output logic [7:0]                     command_o,
  output logic [15:0]                    payload_count_o,
  input  logic                           cfg_we_i,
  input  logic [1:0]                     cfg_idx_i,
  input  logic [15:0]                    cfg_data_i
);
  import sfr_pkg::*;

  cfg_t             cfg_q, cfg_d;
  logic             in_vld_q, in_vld_d;
  logic             op_q;
  logic [ByteW-1:0] byte_q;
  logic             fire;
  logic             res_valid;
  result_t          res;
  result_t          out_data;
  obuf_stat_t       ob_stat;

  assign fire       = in_vld_q && ob_stat.space;
  assign in_ready_o = !in_vld_q || fire;
  assign in_vld_d   = (in_valid_i && in_ready_o) || (in_vld_q && !fire);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_BYTE:    cfg_d.start_byte    = cfg_data_i[ByteW-1:0];
        CFG_END_BYTE:      cfg_d.end_byte      = cfg_data_i[ByteW-1:0];
        CFG_TIMEOUT_TICKS: cfg_d.timeout_ticks = cfg_data_i;
        CFG_LENGTH_LIMIT:  cfg_d.length_limit  = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= StartByteRst;
      cfg_q.end_byte      <= EndByteRst;
      cfg_q.timeout_ticks <= TimeoutTicksRst;
      cfg_q.length_limit  <= LengthLimitRst;
      in_vld_q            <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= operation_i;
      byte_q <= rx_byte_i;
    end
  end

  sfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .op_i        (op_q),
    .byte_i      (byte_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sfr_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fire && res_valid),
    .push_data_i (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data),
    .stat_o      (ob_stat)
  );

  assign kind_o           = out_data.kind;
  assign payload_byte_o   = out_data.payload_byte;
  assign payload_offset_o = out_data.payload_offset;
  assign status_o         = out_data.status;
  assign command_o        = out_data.command;
  assign payload_count_o  = out_data.payload_count;

  // A pending item must not be dropped when the input register refuses new ones.
  a_ready_low_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_vld_q)
    else $error("input refused while input register empty");

  // The parser must not advance when the result buffer is full and stalled.
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ob_stat.count == ObufCntW'(ObufDepth) && !out_ready_i) |-> !fire)
    else $error("parser advanced into a full result buffer");

  // A payload item always carries an ok status.
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_PAYLOAD) |-> (status_o == ST_OK))
    else $error("payload item with nonzero status");

endmodule
